// ----- src/dfa_leftmost_longest_matcher_assert.svh -----
// Assertion helpers for the matcher. Each use sits on a line of its own.
`ifndef DFA_LEFTMOST_LONGEST_MATCHER_ASSERT_SVH
`define DFA_LEFTMOST_LONGEST_MATCHER_ASSERT_SVH

// Same-cycle implication, clocked on clk, off during reset.
`define DFA_LLM_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, clocked on clk, off during reset.
`define DFA_LLM_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ----- src/dfa_llm_pkg.sv -----
`default_nettype none

package dfa_llm_pkg;

  // State ids and symbols
  localparam int STATE_COUNT  = 256;
  localparam int STATE_W      = $clog2(STATE_COUNT);
  localparam int SYMBOL_COUNT = 256;
  localparam int SYM_W        = $clog2(SYMBOL_COUNT);
  localparam int TRANS_AW     = STATE_W + SYM_W;
  localparam int NXT_W        = STATE_W + 1;   // signed target, -1 is dead
  localparam int NUM_W        = STATE_W + 1;   // num_states register

  // Text buffer
  localparam int TEXT_DEPTH = 1024;
  localparam int TEXT_AW    = $clog2(TEXT_DEPTH);
  localparam int LEN_W      = TEXT_AW + 1;
  localparam logic [LEN_W-1:0] TEXT_DEPTH_LEN = LEN_W'(TEXT_DEPTH);

  // Request codes
  typedef enum logic [1:0] {
    REQ_WR_TRANS  = 2'd0,
    REQ_WR_ACCEPT = 2'd1,
    REQ_APPEND    = 2'd2,
    REQ_FIND      = 2'd3
  } req_type_t;

  // Result kinds
  localparam logic RES_APPEND = 1'b0;
  localparam logic RES_FIND   = 1'b1;

endpackage

`default_nettype wire

// ----- src/dfa_llm_req_if.sv -----
`default_nettype none

// Request channel: table writes, text appends and search requests.
interface dfa_llm_req_if;
  logic                                     valid;
  logic                                     ready;
  logic [1:0]                               req_type;
  logic [dfa_llm_pkg::STATE_W-1:0]          state_index;
  logic [dfa_llm_pkg::SYM_W-1:0]            symbol;
  logic signed [dfa_llm_pkg::NXT_W-1:0]     next_state;
  logic                                     accept_bit;
  logic [dfa_llm_pkg::SYM_W-1:0]            text_byte;
  logic                                     first_byte;

  modport source (
    output valid, req_type, state_index, symbol, next_state, accept_bit,
           text_byte, first_byte,
    input  ready
  );

  modport sink (
    input  valid, req_type, state_index, symbol, next_state, accept_bit,
           text_byte, first_byte,
    output ready
  );
endinterface

`default_nettype wire

// ----- src/dfa_llm_res_if.sv -----
`default_nettype none

// Result channel: append status or search result.
interface dfa_llm_res_if;
  logic                              valid;
  logic                              ready;
  logic                              result_kind;
  logic                              prefix_match;
  logic                              found;
  logic [dfa_llm_pkg::TEXT_AW-1:0]   match_start;
  logic [dfa_llm_pkg::LEN_W-1:0]     match_end;
  logic                              buffer_full;

  modport source (
    output valid, result_kind, prefix_match, found, match_start, match_end,
           buffer_full,
    input  ready
  );

  modport sink (
    input  valid, result_kind, prefix_match, found, match_start, match_end,
           buffer_full,
    output ready
  );
endinterface

`default_nettype wire

// ----- src/dfa_llm_ram.sv -----
`default_nettype none

// Simple dual-port RAM: one write port, one read port, registered read data.
module dfa_llm_ram #(
  parameter int AW = 8,
  parameter int DW = 8
) (
  input  wire logic          clk,
  input  wire logic          wr_en,
  input  wire logic [AW-1:0] wr_addr,
  input  wire logic [DW-1:0] wr_data,
  input  wire logic [AW-1:0] rd_addr,
  output      logic [DW-1:0] rd_data
);

  logic [DW-1:0] mem_r [0:(2**AW)-1];
  logic [DW-1:0] rd_data_r;

  // write port
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem_r[wr_addr] <= wr_data;
    end
  end

  // read port, registered read data
  always_ff @(posedge clk) begin
    rd_data_r <= mem_r[rd_addr];
  end

  assign rd_data = rd_data_r;

endmodule

`default_nettype wire

// ----- src/dfa_leftmost_longest_matcher.sv -----
// Table writes (transition, accept flag): one request per cycle while idle, no result.
// Append: steps through S_AP_STEP, S_AP_FLAG and S_OUT; the next request is taken back in S_IDLE.
// Search: each text byte stepped goes through S_FD_TRN, S_FD_ACC and S_FD_CHK (a byte whose
//   transition is dead ends at S_FD_ACC, a restart adds no state), then S_OUT and S_IDLE.
// A stalled output holds the pending result and the input. Reset (synchronous, rst_n
//   low): empty text, cursor 0, start state, num_states 1; RAMs are not cleared.
`default_nettype none

`include "dfa_leftmost_longest_matcher_assert.svh"

module dfa_leftmost_longest_matcher (
  input  wire logic                               clk,
  input  wire logic                               rst_n,
  input  wire logic                               cfg_we,
  input  wire logic [dfa_llm_pkg::NUM_W-1:0]      cfg_wdata,
  dfa_llm_req_if.sink                             in_ch,
  dfa_llm_res_if.source                           out_ch
);

  typedef enum logic [2:0] {
    S_IDLE,
    S_AP_STEP,
    S_AP_FLAG,
    S_FD_TRN,
    S_FD_ACC,
    S_FD_CHK,
    S_OUT
  } state_t;

  localparam int SW = dfa_llm_pkg::STATE_W;
  localparam int LW = dfa_llm_pkg::LEN_W;
  localparam int AW = dfa_llm_pkg::TEXT_AW;
  localparam int NW = dfa_llm_pkg::NUM_W;

  // control
  state_t          state_r, state_nxt;
  logic [NW-1:0]   num_states_r, num_states_nxt;
  logic [LW-1:0]   len_r, len_nxt;
  logic [LW-1:0]   cursor_r, cursor_nxt;
  logic [SW-1:0]   run_state_r, run_state_nxt;
  logic            run_dead_r, run_dead_nxt;
  logic            out_valid_r, out_valid_nxt;

  // per-request working registers
  logic            ap_step_r, ap_step_nxt;
  logic            full_r, full_nxt;
  logic [LW-1:0]   start_r, start_nxt;
  logic [LW-1:0]   pos_r, pos_nxt;
  logic [SW-1:0]   cur_r, cur_nxt;
  logic            any_r, any_nxt;
  logic [LW-1:0]   last_r, last_nxt;

  // pending result
  logic            res_kind_r, res_kind_nxt;
  logic            res_prefix_r, res_prefix_nxt;
  logic            res_found_r, res_found_nxt;
  logic [AW-1:0]   res_start_r, res_start_nxt;
  logic [LW-1:0]   res_end_r, res_end_nxt;
  logic            res_full_r, res_full_nxt;

  // output register
  logic            out_kind_r, out_kind_nxt;
  logic            out_prefix_r, out_prefix_nxt;
  logic            out_found_r, out_found_nxt;
  logic [AW-1:0]   out_start_r, out_start_nxt;
  logic [LW-1:0]   out_end_r, out_end_nxt;
  logic            out_full_r, out_full_nxt;

  // RAM ports
  logic                                 trans_we;
  logic [dfa_llm_pkg::TRANS_AW-1:0]     trans_waddr, trans_raddr;
  logic [dfa_llm_pkg::NXT_W-1:0]        trans_wdata, trans_rdata;
  logic                                 acc_we;
  logic [SW-1:0]                        acc_waddr, acc_raddr;
  logic                                 acc_wdata, acc_rdata;
  logic                                 txt_we;
  logic [AW-1:0]                        txt_waddr, txt_raddr;
  logic [dfa_llm_pkg::SYM_W-1:0]        txt_wdata, txt_rdata;

  logic in_fire;
  logic out_free;
  logic trn_ok;

  function automatic logic state_ok(input logic [SW-1:0] s, input logic [NW-1:0] num);
    return {1'b0, s} < num;
  endfunction

  assign in_fire  = in_ch.valid && in_ch.ready;
  assign out_free = !out_valid_r || out_ch.ready;

  // transition read data: valid target that is not dead
  assign trn_ok = !trans_rdata[dfa_llm_pkg::NXT_W-1]
               && state_ok(trans_rdata[SW-1:0], num_states_r);

  // memories
  dfa_llm_ram #(.AW(dfa_llm_pkg::TRANS_AW), .DW(dfa_llm_pkg::NXT_W)) u_trans_ram (
    .clk     (clk),
    .wr_en   (trans_we),
    .wr_addr (trans_waddr),
    .wr_data (trans_wdata),
    .rd_addr (trans_raddr),
    .rd_data (trans_rdata)
  );

  dfa_llm_ram #(.AW(SW), .DW(1)) u_acc_ram (
    .clk     (clk),
    .wr_en   (acc_we),
    .wr_addr (acc_waddr),
    .wr_data (acc_wdata),
    .rd_addr (acc_raddr),
    .rd_data (acc_rdata)
  );

  dfa_llm_ram #(.AW(AW), .DW(dfa_llm_pkg::SYM_W)) u_text_ram (
    .clk     (clk),
    .wr_en   (txt_we),
    .wr_addr (txt_waddr),
    .wr_data (txt_wdata),
    .rd_addr (txt_raddr),
    .rd_data (txt_rdata)
  );

  // sequencer
  always_comb begin
    logic [LW-1:0] len_eff;
    logic [SW-1:0] rs_eff;
    logic          dead_eff;
    logic          seg_end;
    logic          seg_any;
    logic [LW-1:0] seg_last;
    logic [LW-1:0] pos_inc;
    logic [LW-1:0] start_inc;
    logic [SW-1:0] ap_state;

    state_nxt      = state_r;
    num_states_nxt = cfg_we ? cfg_wdata : num_states_r;
    len_nxt        = len_r;
    cursor_nxt     = cursor_r;
    run_state_nxt  = run_state_r;
    run_dead_nxt   = run_dead_r;
    ap_step_nxt    = ap_step_r;
    full_nxt       = full_r;
    start_nxt      = start_r;
    pos_nxt        = pos_r;
    cur_nxt        = cur_r;
    any_nxt        = any_r;
    last_nxt       = last_r;
    res_kind_nxt   = res_kind_r;
    res_prefix_nxt = res_prefix_r;
    res_found_nxt  = res_found_r;
    res_start_nxt  = res_start_r;
    res_end_nxt    = res_end_r;
    res_full_nxt   = res_full_r;
    out_valid_nxt  = out_valid_r && !out_ch.ready;
    out_kind_nxt   = out_kind_r;
    out_prefix_nxt = out_prefix_r;
    out_found_nxt  = out_found_r;
    out_start_nxt  = out_start_r;
    out_end_nxt    = out_end_r;
    out_full_nxt   = out_full_r;

    len_eff   = in_ch.first_byte ? '0 : len_r;
    rs_eff    = in_ch.first_byte ? '0 : run_state_r;
    dead_eff  = in_ch.first_byte ? 1'b0 : run_dead_r;
    seg_end   = 1'b0;
    seg_any   = any_r;
    seg_last  = last_r;
    pos_inc   = pos_r + LW'(1);
    start_inc = start_r + LW'(1);
    ap_state  = (ap_step_r && trn_ok) ? trans_rdata[SW-1:0] : run_state_r;

    trans_we    = 1'b0;
    trans_waddr = {in_ch.state_index, in_ch.symbol};
    trans_wdata = $unsigned(in_ch.next_state);
    trans_raddr = {rs_eff, in_ch.text_byte};
    acc_we      = 1'b0;
    acc_waddr   = in_ch.state_index;
    acc_wdata   = in_ch.accept_bit;
    acc_raddr   = run_state_r;
    txt_we      = 1'b0;
    txt_waddr   = len_eff[AW-1:0];
    txt_wdata   = in_ch.text_byte;
    txt_raddr   = pos_r[AW-1:0];

    case (state_r)
      S_IDLE: begin
        if (in_fire) begin
          case (in_ch.req_type)
            dfa_llm_pkg::REQ_WR_TRANS: begin
              trans_we = 1'b1;
            end
            dfa_llm_pkg::REQ_WR_ACCEPT: begin
              acc_we = 1'b1;
            end
            dfa_llm_pkg::REQ_APPEND: begin
              if (in_ch.first_byte) begin
                cursor_nxt = '0;
              end
              run_state_nxt = rs_eff;
              if (len_eff >= dfa_llm_pkg::TEXT_DEPTH_LEN) begin
                // buffer full: drop the byte, keep the running state
                full_nxt     = 1'b1;
                ap_step_nxt  = 1'b0;
                len_nxt      = len_eff;
                run_dead_nxt = dead_eff;
              end else begin
                full_nxt     = 1'b0;
                txt_we       = 1'b1;
                len_nxt      = len_eff + LW'(1);
                ap_step_nxt  = !dead_eff && state_ok(rs_eff, num_states_r);
                run_dead_nxt = dead_eff || !state_ok(rs_eff, num_states_r);
              end
              state_nxt = S_AP_STEP;
            end
            dfa_llm_pkg::REQ_FIND: begin
              res_kind_nxt   = dfa_llm_pkg::RES_FIND;
              res_prefix_nxt = 1'b0;
              res_full_nxt   = 1'b0;
              res_found_nxt  = 1'b0;
              res_start_nxt  = '0;
              res_end_nxt    = '0;
              if (!state_ok('0, num_states_r) || cursor_r >= len_r) begin
                cursor_nxt = len_r;
                state_nxt  = S_OUT;
              end else begin
                start_nxt = cursor_r;
                pos_nxt   = cursor_r;
                cur_nxt   = '0;
                any_nxt   = 1'b0;
                last_nxt  = '0;
                txt_raddr = cursor_r[AW-1:0];
                state_nxt = S_FD_TRN;
              end
            end
            default: begin
            end
          endcase
        end
      end

      // transition data for the appended byte; look up its accept flag
      S_AP_STEP: begin
        if (ap_step_r) begin
          if (trn_ok) begin
            run_state_nxt = trans_rdata[SW-1:0];
          end else begin
            run_dead_nxt = 1'b1;
          end
        end
        acc_raddr = ap_state;
        state_nxt = S_AP_FLAG;
      end

      S_AP_FLAG: begin
        res_kind_nxt   = dfa_llm_pkg::RES_APPEND;
        res_prefix_nxt = !run_dead_r && state_ok(run_state_r, num_states_r) && acc_rdata;
        res_found_nxt  = 1'b0;
        res_start_nxt  = '0;
        res_end_nxt    = '0;
        res_full_nxt   = full_r;
        state_nxt      = S_OUT;
      end

      // text byte at pos is here; fetch the transition
      S_FD_TRN: begin
        trans_raddr = {cur_r, txt_rdata};
        state_nxt   = S_FD_ACC;
      end

      S_FD_ACC: begin
        if (trn_ok) begin
          cur_nxt   = trans_rdata[SW-1:0];
          acc_raddr = trans_rdata[SW-1:0];
          state_nxt = S_FD_CHK;
        end else begin
          seg_end = 1'b1;
        end
      end

      // accept flag of the new state; advance or close this start position
      S_FD_CHK: begin
        if (acc_rdata) begin
          seg_any  = 1'b1;
          seg_last = pos_inc;
        end
        any_nxt  = seg_any;
        last_nxt = seg_last;
        if (pos_inc < len_r) begin
          pos_nxt   = pos_inc;
          txt_raddr = pos_inc[AW-1:0];
          state_nxt = S_FD_TRN;
        end else begin
          seg_end = 1'b1;
        end
      end

      S_OUT: begin
        if (out_free) begin
          out_valid_nxt  = 1'b1;
          out_kind_nxt   = res_kind_r;
          out_prefix_nxt = res_prefix_r;
          out_found_nxt  = res_found_r;
          out_start_nxt  = res_start_r;
          out_end_nxt    = res_end_r;
          out_full_nxt   = res_full_r;
          state_nxt      = S_IDLE;
        end
      end

      default: begin
        state_nxt = S_IDLE;
      end
    endcase

    // walk from one start position ended: report or restart one further on
    if (seg_end) begin
      if (seg_any) begin
        res_found_nxt = 1'b1;
        res_start_nxt = start_r[AW-1:0];
        res_end_nxt   = seg_last;
        cursor_nxt    = seg_last;
        state_nxt     = S_OUT;
      end else if (start_inc < len_r) begin
        start_nxt = start_inc;
        pos_nxt   = start_inc;
        cur_nxt   = '0;
        any_nxt   = 1'b0;
        last_nxt  = '0;
        txt_raddr = start_inc[AW-1:0];
        state_nxt = S_FD_TRN;
      end else begin
        cursor_nxt = len_r;
        state_nxt  = S_OUT;
      end
    end
  end

  // state and registered outputs
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= S_IDLE;
      num_states_r <= NW'(1);
      len_r        <= '0;
      cursor_r     <= '0;
      run_state_r  <= '0;
      run_dead_r   <= 1'b0;
      out_valid_r  <= 1'b0;
    end else begin
      state_r      <= state_nxt;
      num_states_r <= num_states_nxt;
      len_r        <= len_nxt;
      cursor_r     <= cursor_nxt;
      run_state_r  <= run_state_nxt;
      run_dead_r   <= run_dead_nxt;
      out_valid_r  <= out_valid_nxt;
    end
    ap_step_r    <= ap_step_nxt;
    full_r       <= full_nxt;
    start_r      <= start_nxt;
    pos_r        <= pos_nxt;
    cur_r        <= cur_nxt;
    any_r        <= any_nxt;
    last_r       <= last_nxt;
    res_kind_r   <= res_kind_nxt;
    res_prefix_r <= res_prefix_nxt;
    res_found_r  <= res_found_nxt;
    res_start_r  <= res_start_nxt;
    res_end_r    <= res_end_nxt;
    res_full_r   <= res_full_nxt;
    out_kind_r   <= out_kind_nxt;
    out_prefix_r <= out_prefix_nxt;
    out_found_r  <= out_found_nxt;
    out_start_r  <= out_start_nxt;
    out_end_r    <= out_end_nxt;
    out_full_r   <= out_full_nxt;
  end

  // ports
  assign in_ch.ready         = (state_r == S_IDLE);
  assign out_ch.valid        = out_valid_r;
  assign out_ch.result_kind  = out_kind_r;
  assign out_ch.prefix_match = out_prefix_r;
  assign out_ch.found        = out_found_r;
  assign out_ch.match_start  = out_start_r;
  assign out_ch.match_end    = out_end_r;
  assign out_ch.buffer_full  = out_full_r;

  // checks
  `DFA_LLM_ASSERT_IMP(a_len_bound, 1'b1, len_r <= dfa_llm_pkg::TEXT_DEPTH_LEN, "text length overflow")
  `DFA_LLM_ASSERT_IMP(a_cursor_le_len, 1'b1, cursor_r <= len_r, "cursor beyond text end")
  `DFA_LLM_ASSERT_IMP(a_match_nonempty, out_valid_r && out_found_r, out_end_r > {1'b0, out_start_r}, "empty match reported")
  `DFA_LLM_ASSERT_IMP(a_walk_in_text, state_r == S_FD_TRN, pos_r < len_r && start_r <= pos_r, "search walk outside text")
  `DFA_LLM_ASSERT_NXT(a_busy_after_req, in_fire && in_ch.req_type[1], state_r != S_IDLE, "append or search not started")

endmodule

`default_nettype wire
